### hw/rtl/rndis_packet_aggregating_framer_defines.svh
// assertion macros used by the framer checker
`ifndef RNDIS_PACKET_AGGREGATING_FRAMER_DEFINES_SVH
`define RNDIS_PACKET_AGGREGATING_FRAMER_DEFINES_SVH

// a stalled transfer keeps valid high and its payload unchanged
`define RPAF_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
    else $error("stalled transfer changed");

// a condition on the ports implies another in the same cycle
`define RPAF_ASSERT_IMPL(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |-> (expr)) \
    else $error("port relation violated");

`endif

### hw/rtl/rpaf_pkg.sv
// types and constants of the packet aggregating framer
package rpaf_pkg;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_PAYLOAD = 2'd1,
    FUNC_END     = 2'd2,
    FUNC_BAD     = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e_t;

  // configuration register indexes
  localparam logic [7:0] CFG_SIZE_LIMIT  = 8'd0;
  localparam logic [7:0] CFG_COUNT_LIMIT = 8'd1;

  localparam logic [15:0] SIZE_LIMIT_RST  = 16'd14336;
  localparam logic [7:0]  COUNT_LIMIT_RST = 8'd64;

  // message header layout
  localparam int unsigned   HDR_WORDS       = 11;
  localparam logic [5:0]    HDR_BYTES       = 6'd44;
  localparam logic [31:0]   MSG_TYPE_PACKET = 32'h0000_0001;
  localparam logic [31:0]   DATA_OFFSET_VAL = 32'd36;
  localparam logic [3:0]    HDR_LAST_IDX    = 4'(HDR_WORDS - 1);

  // width of offsets carried in the command queue (widest supported)
  localparam int unsigned CMD_OFS_W = 32;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] packet_len;
    logic [31:0] data_word;
  } in_t;

  typedef struct packed {
    kind_e_t     kind;
    logic [31:0] word_out;
    logic [15:0] byte_offset;
    logic        last;
    logic        may_continue;
    logic [15:0] transfer_length;
  } out_t;

  // one classified item for the back end
  typedef struct packed {
    kind_e_t              kind;
    logic [31:0]          word;
    logic [CMD_OFS_W-1:0] ofs;
    logic                 cont;
    logic [15:0]          tlen;
    logic [14:0]          msg_len;
    logic [13:0]          len;
  } cmd_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/rpaf_front.sv
// front end: accepts items, keeps the transfer counters and builds commands
module rpaf_front #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rpaf_pkg::in_t   in_data,
  input  logic            cfg_valid,
  input  logic [7:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  rpaf_pkg::q_stat_t q_stat,
  output logic            push,
  output rpaf_pkg::cmd_t  push_cmd
);

  localparam int unsigned CW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

  logic [15:0]            size_limit_r;
  logic [7:0]             count_limit_r;
  logic [OFFSET_BITS-1:0] byte_total_r, byte_total_nxt;
  logic [7:0]             packet_count_r, packet_count_nxt;
  logic [OFFSET_BITS-1:0] write_offset_r, write_offset_nxt;
  logic [13:0]            bytes_rem_r, bytes_rem_nxt;

  logic [14:0]            msg_len;
  logic [2:0]             nbytes;
  logic [31:0]            mask;
  logic                   cont_now;
  logic                   cont_start;

  function automatic logic [OFFSET_BITS-1:0] sat_add(
    input logic [OFFSET_BITS-1:0] a,
    input logic [OFFSET_BITS-1:0] b
  );
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : s[OFFSET_BITS-1:0];
  endfunction

  function automatic logic [15:0] cap16(input logic [OFFSET_BITS-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return (w > CW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic fits(
    input logic [OFFSET_BITS-1:0] bt,
    input logic [7:0]             pc,
    input logic [15:0]            sl,
    input logic [7:0]             cl
  );
    return !((CW'(bt) > CW'(sl)) || (pc >= cl));
  endfunction

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // start packet arithmetic
  assign msg_len          = (15'(in_data.packet_len) + 15'd47) & ~15'd3;
  assign byte_total_nxt   = sat_add(byte_total_r, OFFSET_BITS'(msg_len));
  assign packet_count_nxt = (packet_count_r == 8'hFF) ? packet_count_r
                                                     : packet_count_r + 8'd1;
  assign cont_start = fits(byte_total_nxt, packet_count_nxt, size_limit_r, count_limit_r);
  assign cont_now   = fits(byte_total_r, packet_count_r, size_limit_r, count_limit_r);

  // payload byte mask from bytes still expected
  assign nbytes = (bytes_rem_r >= 14'd4) ? 3'd4 : bytes_rem_r[2:0];
  always_comb begin
    unique case (nbytes)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  // command build
  always_comb begin
    push_cmd         = '0;
    push_cmd.kind    = rpaf_pkg::KIND_ERROR;
    push_cmd.ofs     = rpaf_pkg::CMD_OFS_W'(write_offset_r);
    push_cmd.cont    = cont_now;
    push_cmd.msg_len = msg_len;
    push_cmd.len     = in_data.packet_len;
    unique case (rpaf_pkg::func_e_t'(in_data.func))
      rpaf_pkg::FUNC_START: begin
        push_cmd.kind = rpaf_pkg::KIND_HEADER;
        push_cmd.ofs  = rpaf_pkg::CMD_OFS_W'(byte_total_r);
        push_cmd.cont = cont_start;
      end
      rpaf_pkg::FUNC_PAYLOAD: begin
        if (bytes_rem_r != 14'd0) begin
          push_cmd.kind = rpaf_pkg::KIND_PAYLOAD;
          push_cmd.word = in_data.data_word & mask;
        end
      end
      rpaf_pkg::FUNC_END: begin
        push_cmd.kind = rpaf_pkg::KIND_END;
        push_cmd.ofs  = '0;
        push_cmd.cont = 1'b1;
        push_cmd.tlen = cap16(byte_total_r);
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_limit_r  <= rpaf_pkg::SIZE_LIMIT_RST;
      count_limit_r <= rpaf_pkg::COUNT_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rpaf_pkg::CFG_SIZE_LIMIT:  size_limit_r  <= cfg_data;
        rpaf_pkg::CFG_COUNT_LIMIT: count_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // transfer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_total_r   <= '0;
      packet_count_r <= '0;
      write_offset_r <= '0;
      bytes_rem_r    <= '0;
    end else if (push) begin
      unique case (rpaf_pkg::func_e_t'(in_data.func))
        rpaf_pkg::FUNC_START: begin
          byte_total_r   <= byte_total_nxt;
          packet_count_r <= packet_count_nxt;
          write_offset_r <= sat_add(byte_total_r, OFFSET_BITS'(rpaf_pkg::HDR_BYTES));
          bytes_rem_r    <= in_data.packet_len;
        end
        rpaf_pkg::FUNC_PAYLOAD: begin
          if (bytes_rem_r != 14'd0) begin
            write_offset_r <= sat_add(write_offset_r, OFFSET_BITS'(3'd4));
            bytes_rem_r    <= bytes_rem_r - 14'(nbytes);
          end
        end
        rpaf_pkg::FUNC_END: begin
          byte_total_r   <= '0;
          packet_count_r <= '0;
          write_offset_r <= '0;
          bytes_rem_r    <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/rpaf_queue.sv
// short command queue between front and back
module rpaf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rpaf_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output rpaf_pkg::cmd_t    head,
  output rpaf_pkg::q_stat_t q_stat
);

  rpaf_pkg::cmd_t                 mem_r [rpaf_pkg::Q_DEPTH];
  logic [rpaf_pkg::Q_PTR_W-1:0]   wptr_r;
  logic [rpaf_pkg::Q_PTR_W-1:0]   rptr_r;
  logic [rpaf_pkg::Q_PTR_W:0]     cnt_r;

  assign q_stat.full  = (cnt_r == (rpaf_pkg::Q_PTR_W+1)'(rpaf_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + rpaf_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + rpaf_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (rpaf_pkg::Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (rpaf_pkg::Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

### hw/rtl/rpaf_back.sv
// back end: expands commands into result words behind an output register
module rpaf_back #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rpaf_pkg::cmd_t    head,
  input  rpaf_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rpaf_pkg::out_t    out_data
);

  localparam int unsigned CW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

  rpaf_pkg::out_t         out_r, out_nxt;
  logic                   out_valid_r;
  logic [3:0]             idx_r;
  logic                   load;
  logic                   is_hdr;
  logic                   hdr_last;
  logic [OFFSET_BITS-1:0] base_ofs;
  logic [OFFSET_BITS:0]   hdr_sum;
  logic [OFFSET_BITS-1:0] hdr_ofs;

  function automatic logic [15:0] cap16(input logic [OFFSET_BITS-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return (w > CW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  assign load     = !out_valid_r || out_ready;
  assign is_hdr   = (head.kind == rpaf_pkg::KIND_HEADER);
  assign hdr_last = (idx_r == rpaf_pkg::HDR_LAST_IDX);
  assign pop      = load && !q_stat.empty && (!is_hdr || hdr_last);

  // header word offset, saturating
  assign base_ofs = head.ofs[OFFSET_BITS-1:0];
  assign hdr_sum  = {1'b0, base_ofs} + (OFFSET_BITS+1)'({idx_r, 2'b00});
  assign hdr_ofs  = hdr_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : hdr_sum[OFFSET_BITS-1:0];

  // next result word
  always_comb begin
    out_nxt                 = '0;
    out_nxt.kind            = head.kind;
    out_nxt.may_continue    = head.cont;
    out_nxt.last            = 1'b1;
    out_nxt.transfer_length = head.tlen;
    out_nxt.word_out        = head.word;
    out_nxt.byte_offset     = cap16(base_ofs);
    if (is_hdr) begin
      out_nxt.last        = hdr_last;
      out_nxt.byte_offset = cap16(hdr_ofs);
      unique case (idx_r)
        4'd0:    out_nxt.word_out = rpaf_pkg::MSG_TYPE_PACKET;
        4'd1:    out_nxt.word_out = 32'(head.msg_len);
        4'd2:    out_nxt.word_out = rpaf_pkg::DATA_OFFSET_VAL;
        4'd3:    out_nxt.word_out = 32'(head.len);
        default: out_nxt.word_out = '0;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) begin
      out_r <= out_nxt;
    end
  end

  // output valid and header word counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= !q_stat.empty;
      if (!q_stat.empty && is_hdr) begin
        idx_r <= hdr_last ? 4'd0 : idx_r + 4'd1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/rndis_packet_aggregating_framer.sv
// packet aggregating framer: an accepted item's command is registered in the queue, then in the output register
// payload, end and error items give one result each and sustain one per cycle while the result side is ready
// a start item gives 11 header words, one per cycle while the result side is ready, from the back end's word counter
// the 4-entry command queue lets the front keep taking items while headers drain
// rst_n (synchronous) empties queue and output, clears counters, restores limits
module rndis_packet_aggregating_framer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rpaf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rpaf_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  rpaf_pkg::q_stat_t q_stat;
  rpaf_pkg::cmd_t    push_cmd;
  rpaf_pkg::cmd_t    head;
  logic              push;
  logic              pop;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  rpaf_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rpaf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  rpaf_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/rpaf_checker.sv
// port checker for the packet aggregating framer, bound to the top level
`include "rndis_packet_aggregating_framer_defines.svh"

module rpaf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input rpaf_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input rpaf_pkg::out_t out_data
);

  // input channel holds a stalled transfer
  `RPAF_ASSERT_HOLD(a_in_hold, in_valid, in_ready, in_data)

  // result channel holds a stalled transfer
  `RPAF_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_data)

  // end summary is a lone word with no data and always allows more
  `RPAF_ASSERT_IMPL(a_end_form, out_valid && (out_data.kind == rpaf_pkg::KIND_END), out_data.last && out_data.may_continue && (out_data.word_out == 32'd0) && (out_data.byte_offset == 16'd0))

  // transfer length only shows in the end summary
  `RPAF_ASSERT_IMPL(a_tlen_end_only, out_valid && (out_data.kind != rpaf_pkg::KIND_END), out_data.transfer_length == 16'd0)

  // error result is a lone zero word
  `RPAF_ASSERT_IMPL(a_err_form, out_valid && (out_data.kind == rpaf_pkg::KIND_ERROR), out_data.last && (out_data.word_out == 32'd0))

endmodule

bind rndis_packet_aggregating_framer rpaf_checker u_rpaf_checker (.*);

### dv/tb_top.sv
// testbench for the packet aggregating framer: directed and random transfers checked by a built-in predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 200;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  rpaf_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rpaf_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [7:0]     cfg_index = '0;
  logic [15:0]    cfg_data = '0;

  // items waiting for the driver and framer words still to come
  rpaf_pkg::in_t  item_q[$];
  rpaf_pkg::out_t frame_q[$];

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  logic        calm = 1'b0;

  // predictor state and its copy of the limits
  logic [15:0] total_bytes = '0;
  logic [7:0]  pkt_count = '0;
  logic [15:0] wr_ofs = '0;
  logic [15:0] bytes_left = '0;
  logic [15:0] lim_size = rpaf_pkg::SIZE_LIMIT_RST;
  logic [7:0]  lim_count = rpaf_pkg::COUNT_LIMIT_RST;

  rndis_packet_aggregating_framer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] sat_add16(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic room_left();
    return !(total_bytes > lim_size || pkt_count >= lim_count);
  endfunction

  // works out the framer words that one accepted item causes
  task automatic frame_item(input rpaf_pkg::in_t it);
    rpaf_pkg::out_t r;
    int unsigned    msg_len;
    int unsigned    n;
    logic [15:0]    start;
    logic [31:0]    mask;
    logic           cont;
    r = '0;
    r.last = 1'b1;
    case (rpaf_pkg::func_e_t'(it.func))
      rpaf_pkg::FUNC_START: begin
        msg_len = (32'(it.packet_len) + 32'(rpaf_pkg::HDR_BYTES) + 32'd3) & ~32'd3;
        start = total_bytes;
        total_bytes = sat_add16(32'(total_bytes), msg_len);
        if (pkt_count != 8'hFF) pkt_count = pkt_count + 8'd1;
        wr_ofs = sat_add16(32'(start), 32'(rpaf_pkg::HDR_BYTES));
        bytes_left = 16'(it.packet_len);
        cont = room_left();
        for (int i = 0; i < int'(rpaf_pkg::HDR_WORDS); i++) begin
          r.kind = rpaf_pkg::KIND_HEADER;
          case (i)
            0: r.word_out = rpaf_pkg::MSG_TYPE_PACKET;
            1: r.word_out = msg_len;
            2: r.word_out = rpaf_pkg::DATA_OFFSET_VAL;
            3: r.word_out = 32'(it.packet_len);
            default: r.word_out = '0;
          endcase
          r.byte_offset = sat_add16(32'(start), 32'(4 * i));
          r.last = (i == int'(rpaf_pkg::HDR_WORDS) - 1);
          r.may_continue = cont;
          frame_q.push_back(r);
        end
      end
      rpaf_pkg::FUNC_PAYLOAD: begin
        r.byte_offset = wr_ofs;
        r.may_continue = room_left();
        if (bytes_left == 16'd0) begin
          r.kind = rpaf_pkg::KIND_ERROR;
        end else begin
          n = (bytes_left < 16'd4) ? 32'(bytes_left) : 32'd4;
          mask = (n == 32'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
          r.kind = rpaf_pkg::KIND_PAYLOAD;
          r.word_out = it.data_word & mask;
          wr_ofs = sat_add16(32'(wr_ofs), 32'd4);
          bytes_left = bytes_left - 16'(n);
        end
        frame_q.push_back(r);
      end
      rpaf_pkg::FUNC_END: begin
        r.kind = rpaf_pkg::KIND_END;
        r.may_continue = 1'b1;
        r.transfer_length = total_bytes;
        total_bytes = '0;
        pkt_count = '0;
        wr_ofs = '0;
        bytes_left = '0;
        frame_q.push_back(r);
      end
      default: begin
        r.kind = rpaf_pkg::KIND_ERROR;
        r.byte_offset = wr_ofs;
        r.may_continue = room_left();
        frame_q.push_back(r);
      end
    endcase
  endtask

  // input driver: offers queued items with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_item(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (item_q.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
          in_data <= item_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side ready: random stalls and the occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 29);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // monitor: each result transfer against the oldest expected word
  always @(posedge clk) begin : watch
    rpaf_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: no result expected, actual %p", $time, out_data);
      end else begin
        want = frame_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data.kind));
        check_field("word_out", want.word_out, out_data.word_out);
        check_field("byte_offset", 32'(want.byte_offset), 32'(out_data.byte_offset));
        check_field("last", 32'(want.last), 32'(out_data.last));
        check_field("may_continue", 32'(want.may_continue), 32'(out_data.may_continue));
        check_field("transfer_length", 32'(want.transfer_length),
                    32'(out_data.transfer_length));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rndis_packet_aggregating_framer: mismatch");
      $finish;
    end
  end

  task automatic queue_item(input rpaf_pkg::func_e_t f, input int unsigned len,
                            input logic [31:0] data);
    rpaf_pkg::in_t it;
    it.func = f;
    it.packet_len = len[13:0];
    it.data_word = data;
    item_q.push_back(it);
    n_queued++;
  endtask

  // one packet: start plus its payload, sometimes cut short or overrun
  task automatic add_packet();
    int unsigned len;
    int unsigned words;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) len = $urandom_range(3);
    else if (pick < 82) len = $urandom_range(64);
    else if (pick < 96) len = $urandom_range(200, 65);
    else len = $urandom_range(16383, 8192);
    words = (len + 3) / 4;
    pick = $urandom_range(99);
    if (len > 200) words = $urandom_range(6);
    else if (pick < 10) words = (words > 0) ? $urandom_range(words - 1) : 0;
    else if (pick < 20) words = words + 1 + $urandom_range(1);
    queue_item(rpaf_pkg::FUNC_START, len, $urandom);
    repeat (words) queue_item(rpaf_pkg::FUNC_PAYLOAD, $urandom_range(16383), $urandom);
  endtask

  // a run of packets, usually closed by an end item, with some noise
  task automatic add_transfer(input int unsigned max_pkts);
    int unsigned pkts;
    pkts = $urandom_range(max_pkts, 1);
    repeat (pkts) begin
      if ($urandom_range(99) < 6)
        queue_item(rpaf_pkg::func_e_t'($urandom_range(3)), $urandom_range(16383), $urandom);
      add_packet();
    end
    if ($urandom_range(99) < 90)
      queue_item(rpaf_pkg::FUNC_END, $urandom_range(16383), $urandom);
  endtask

  // every queued item taken and every expected word seen
  task automatic wait_drained();
    do @(posedge clk); while (n_accepted != n_queued || frame_q.size() != 0);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rpaf_pkg::CFG_SIZE_LIMIT) lim_size = value;
    else if (idx == rpaf_pkg::CFG_COUNT_LIMIT) lim_count = value[7:0];
    @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned n_items, input int unsigned max_pkts);
    int unsigned target;
    target = n_queued + n_items;
    while (n_queued < target) add_transfer(max_pkts);
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: errors, short and long packets, abandoning, ends
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 16383, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_BAD, 16383, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_START, 0, 32'h0);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_START, 5, 32'h0);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_START, 3, 32'h0);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_START, 2, 32'h0);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_START, 1, 32'h0);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_START, 16383, 32'hFFFF_FFFF);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'h0);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'hA5A5_A5A5);
    queue_item(rpaf_pkg::FUNC_START, 7, 32'h0);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'h1234_5678);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'h9ABC_DEF0);
    queue_item(rpaf_pkg::FUNC_START, 8, 32'h0);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, 32'h5A5A_5A5A);
    queue_item(rpaf_pkg::FUNC_END, 0, 32'h0);
    queue_item(rpaf_pkg::FUNC_END, 16383, 32'hFFFF_FFFF);
    wait_drained();

    // lowest limits: every transfer full at once
    write_reg(rpaf_pkg::CFG_SIZE_LIMIT, 16'd0);
    write_reg(rpaf_pkg::CFG_COUNT_LIMIT, 16'd1);
    random_phase(4, 2);
    wait_drained();

    // highest limits, byte counters driven into saturation
    write_reg(rpaf_pkg::CFG_SIZE_LIMIT, 16'hFFFF);
    write_reg(rpaf_pkg::CFG_COUNT_LIMIT, 16'd255);
    repeat (5) begin
      queue_item(rpaf_pkg::FUNC_START, 16383, $urandom);
      queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, $urandom);
    end
    queue_item(rpaf_pkg::FUNC_START, 0, $urandom);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, $urandom);
    queue_item(rpaf_pkg::FUNC_START, 9, $urandom);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, $urandom);
    queue_item(rpaf_pkg::FUNC_END, 0, $urandom);
    wait_drained();

    // packet count saturation
    repeat (258) queue_item(rpaf_pkg::FUNC_START, $urandom_range(3), $urandom);
    queue_item(rpaf_pkg::FUNC_PAYLOAD, 0, $urandom);
    queue_item(rpaf_pkg::FUNC_END, 0, $urandom);
    wait_drained();

    // mid limits with a long result hold-off while items keep coming
    write_reg(rpaf_pkg::CFG_SIZE_LIMIT, 16'($urandom_range(2000, 200)));
    write_reg(rpaf_pkg::CFG_COUNT_LIMIT, 16'($urandom_range(8, 2)));
    random_phase(30, 6);
    holds_asked++;
    wait_drained();

    // no idling on either side
    calm = 1'b1;
    write_reg(rpaf_pkg::CFG_SIZE_LIMIT, 16'd1000);
    write_reg(rpaf_pkg::CFG_COUNT_LIMIT, 16'd10);
    random_phase(20, 4);
    wait_drained();
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("rndis_packet_aggregating_framer: match");
    end else begin
      $display("rndis_packet_aggregating_framer: mismatch");
    end
    $finish;
  end

endmodule
